@@ rtl/lvrk2_pkg.sv @@
package lvrk2_pkg;

	// Word format: signed fixed point, Q16.16 in 32-bit words.
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	// Unsigned coefficient widths.
	localparam int WGT_BITS  = FRAC_BITS + 1;
	localparam int STEP_BITS = WORD_BITS - 1;
	// The shared unit takes operands one bit wider than a word, so that the
	// unsigned coefficients and signed words share a single signed multiplier.
	localparam int OPND_BITS = WORD_BITS + 1;
	localparam int PROD_BITS = 2 * OPND_BITS;
	localparam int SUM_BITS  = OPND_BITS + 1;

	localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	// Register reset values.
	localparam logic [WORD_BITS-1:0] COEF_RESET   = WORD_BITS'(1) << FRAC_BITS;
	localparam logic [WGT_BITS-1:0]  WGT_ONE      = WGT_BITS'(1) << FRAC_BITS;
	localparam logic [STEP_BITS-1:0] STEP_RESET   = STEP_BITS'(6554);
	localparam logic [STEP_BITS-1:0] OFFSET_RESET = STEP_BITS'(3277);

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 3;
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_PREY_GROWTH    = 3'd0,
		CFG_PREDATION_RATE = 3'd1,
		CFG_PREDATOR_GAIN  = 3'd2,
		CFG_PREDATOR_DEATH = 3'd3,
		CFG_STAGE_WEIGHT   = 3'd4,
		CFG_STEP_SIZE      = 3'd5,
		CFG_STAGE_OFFSET   = 3'd6
	} cfg_idx_t;

	// Item kinds.
	typedef enum logic {
		FUNC_LOAD    = 1'b0,
		FUNC_ADVANCE = 1'b1
	} func_t;

	// Operations of the shared unit.
	typedef enum logic [1:0] {
		ALU_MUL = 2'd0,
		ALU_ADD = 2'd1,
		ALU_SUB = 2'd2
	} alu_op_t;

	// Operand sources: working registers, then coefficients.
	typedef enum logic [4:0] {
		SRC_X, SRC_Y, SRC_P, SRC_T0, SRC_T1, SRC_K1X, SRC_K1Y, SRC_K2X, SRC_K2Y,
		SRC_XM, SRC_YM, SRC_A, SRC_B, SRC_C, SRC_D, SRC_OM, SRC_W, SRC_H, SRC_OFF
	} src_t;

	// Write-back destinations.
	typedef enum logic [3:0] {
		DST_X, DST_Y, DST_P, DST_T0, DST_T1, DST_K1X, DST_K1Y, DST_K2X, DST_K2Y,
		DST_XM, DST_YM
	} dst_t;

	typedef struct packed {
		alu_op_t op;
		src_t    a;
		src_t    b;
		dst_t    dst;
	} uop_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	// Controls from the sequencer to the datapath.
	typedef struct packed {
		logic ready;
		logic load_init;
		logic clr_sat;
		logic wr_en;
		logic out_load;
		uop_t uop;
	} ctrl_t;

	localparam int PROG_LEN = 28;
	localparam int PC_BITS  = $clog2(PROG_LEN);
	localparam logic [PC_BITS-1:0] PC_LAST = PC_BITS'(PROG_LEN - 1);

	// Micro-program for one advance step: derivative at the current point,
	// midpoint, derivative at the midpoint, weighted blend, then the update.
	function automatic uop_t prog_rom(input logic [PC_BITS-1:0] pc);
		uop_t u;
		case (pc)
			5'd0:    u = '{ALU_MUL, SRC_X,   SRC_Y,   DST_P};
			5'd1:    u = '{ALU_MUL, SRC_A,   SRC_X,   DST_T0};
			5'd2:    u = '{ALU_MUL, SRC_B,   SRC_P,   DST_T1};
			5'd3:    u = '{ALU_SUB, SRC_T0,  SRC_T1,  DST_K1X};
			5'd4:    u = '{ALU_MUL, SRC_C,   SRC_P,   DST_T0};
			5'd5:    u = '{ALU_MUL, SRC_D,   SRC_Y,   DST_T1};
			5'd6:    u = '{ALU_SUB, SRC_T0,  SRC_T1,  DST_K1Y};
			5'd7:    u = '{ALU_MUL, SRC_K1X, SRC_OFF, DST_T0};
			5'd8:    u = '{ALU_ADD, SRC_X,   SRC_T0,  DST_XM};
			5'd9:    u = '{ALU_MUL, SRC_K1Y, SRC_OFF, DST_T0};
			5'd10:   u = '{ALU_ADD, SRC_Y,   SRC_T0,  DST_YM};
			5'd11:   u = '{ALU_MUL, SRC_XM,  SRC_YM,  DST_P};
			5'd12:   u = '{ALU_MUL, SRC_A,   SRC_XM,  DST_T0};
			5'd13:   u = '{ALU_MUL, SRC_B,   SRC_P,   DST_T1};
			5'd14:   u = '{ALU_SUB, SRC_T0,  SRC_T1,  DST_K2X};
			5'd15:   u = '{ALU_MUL, SRC_C,   SRC_P,   DST_T0};
			5'd16:   u = '{ALU_MUL, SRC_D,   SRC_YM,  DST_T1};
			5'd17:   u = '{ALU_SUB, SRC_T0,  SRC_T1,  DST_K2Y};
			5'd18:   u = '{ALU_MUL, SRC_OM,  SRC_K1X, DST_T0};
			5'd19:   u = '{ALU_MUL, SRC_W,   SRC_K2X, DST_T1};
			5'd20:   u = '{ALU_ADD, SRC_T0,  SRC_T1,  DST_T0};
			5'd21:   u = '{ALU_MUL, SRC_H,   SRC_T0,  DST_T0};
			5'd22:   u = '{ALU_ADD, SRC_X,   SRC_T0,  DST_X};
			5'd23:   u = '{ALU_MUL, SRC_OM,  SRC_K1Y, DST_T0};
			5'd24:   u = '{ALU_MUL, SRC_W,   SRC_K2Y, DST_T1};
			5'd25:   u = '{ALU_ADD, SRC_T0,  SRC_T1,  DST_T0};
			5'd26:   u = '{ALU_MUL, SRC_H,   SRC_T0,  DST_T0};
			5'd27:   u = '{ALU_ADD, SRC_Y,   SRC_T0,  DST_Y};
			default: u = '{ALU_ADD, SRC_X,   SRC_X,   DST_T0};
		endcase
		return u;
	endfunction

endpackage

@@ rtl/lvrk2_alu.sv @@
module lvrk2_alu
	import lvrk2_pkg::*;
(
	input  logic                        clk,
	input  alu_op_t                     op,
	input  logic signed [OPND_BITS-1:0] a,
	input  logic signed [OPND_BITS-1:0] b,
	output logic        [WORD_BITS-1:0] result,
	output logic                        sat
);

	logic signed [PROD_BITS-1:0]                      prod_s1;
	logic        [PROD_BITS-FRAC_BITS-WORD_BITS:0]    prod_top;
	logic                                             prod_in_range;
	logic signed [SUM_BITS-1:0]                       sum;
	logic        [SUM_BITS-WORD_BITS:0]               sum_top;
	logic                                             sum_in_range;

	// The multiplier is registered; its result is scaled and saturated combinationally from that register.
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	// Dropping the fraction bits of a two's complement product rounds toward
	// minus infinity; the result fits when every bit above the word agrees.
	assign prod_top      = prod_s1[PROD_BITS-1:FRAC_BITS+WORD_BITS-1];
	assign prod_in_range = (&prod_top) || !(|prod_top);

	// Exact sum or difference one bit wider than the operands.
	always_comb begin
		if (op == ALU_SUB) begin
			sum = {a[OPND_BITS-1], a} - {b[OPND_BITS-1], b};
		end else begin
			sum = {a[OPND_BITS-1], a} + {b[OPND_BITS-1], b};
		end
	end

	assign sum_top      = sum[SUM_BITS-1:WORD_BITS-1];
	assign sum_in_range = (&sum_top) || !(|sum_top);

	// Select and saturate the result of the current operation.
	always_comb begin
		case (op)
			ALU_MUL: begin
				sat = !prod_in_range;
				if (prod_in_range) begin
					result = prod_s1[FRAC_BITS+WORD_BITS-1:FRAC_BITS];
				end else begin
					result = prod_s1[PROD_BITS-1] ? WORD_MIN : WORD_MAX;
				end
			end
			default: begin
				sat = !sum_in_range;
				if (sum_in_range) begin
					result = sum[WORD_BITS-1:0];
				end else begin
					result = sum[SUM_BITS-1] ? WORD_MIN : WORD_MAX;
				end
			end
		endcase
	end

endmodule

@@ rtl/lvrk2_ctrl.sv @@
module lvrk2_ctrl
	import lvrk2_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  func_t in_func,
	input  logic  out_free,
	output ctrl_t cs
);

	state_t             state_q, state_d;
	logic [PC_BITS-1:0] pc_q, pc_d;
	logic               phase_q, phase_d;

	// State register, program counter and multiply phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			phase_q <= phase_d;
		end
	end

	// Next state and datapath controls. A multiply first loads the multiplier register
	// with the phase bit clear and writes back with the phase bit set; add and subtract
	// write back at once.
	always_comb begin
		state_d      = state_q;
		pc_d         = pc_q;
		phase_d      = phase_q;
		cs           = '0;
		cs.uop       = prog_rom(pc_q);
		unique case (state_q)
			ST_IDLE: begin
				cs.ready = 1'b1;
				if (in_valid) begin
					cs.clr_sat = 1'b1;
					pc_d       = '0;
					phase_d    = 1'b0;
					if (in_func == FUNC_LOAD) begin
						cs.load_init = 1'b1;
						state_d      = ST_FINISH;
					end else begin
						state_d = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				if (cs.uop.op == ALU_MUL && !phase_q) begin
					phase_d = 1'b1;
				end else begin
					cs.wr_en = 1'b1;
					phase_d  = 1'b0;
					if (pc_q == PC_LAST) begin
						state_d = ST_FINISH;
					end else begin
						pc_d = pc_q + 1'b1;
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cs.out_load = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// A multiply never writes back before its product has been registered.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cs.wr_en && cs.uop.op == ALU_MUL) |-> phase_q)
		else $error("multiply written back in its issue cycle");

	// The program counter stays within the micro-program.
	assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PC_LAST)
		else $error("program counter beyond the micro-program");

	// The last write-back of a step leads straight to the result hand-over.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && cs.wr_en && pc_q == PC_LAST) |=> (state_q == ST_FINISH))
		else $error("step did not finish after its last operation");

endmodule

@@ rtl/lotka_volterra_rk2_step_unit.sv @@
// Channel   Signals                          Payload
// config    cfg_we, cfg_index, cfg_wdata     one register written per cycle, no wait
// input     s_axis_tvalid/tready/tdata/tuser tdata: init_prey, init_predator; tuser: func
// output    m_axis_tvalid/tready/tdata/tuser tdata: prey_out, predator_out; tuser: overflow
//
// An advance item runs a 28-operation micro-program on one shared unit: 18 multiplies
// (multiplier register, then scale and saturate) and 10 saturating adds or subtracts.
// It is accepted in the idle state and its result handed over in the finish state;
// no new item is accepted before that hand-over. A load item goes straight from accept
// to hand-over. Reset clears the levels to zero and the coefficients to their defaults.
// A stalled output keeps its result in the output register; the block still accepts
// and runs the next item, then waits in its hand-over state until that register is free.
module lotka_volterra_rk2_step_unit
	import lvrk2_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [WORD_BITS-1:0]      cfg_wdata,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [2*WORD_BITS-1:0]    s_axis_tdata,  // init_prey, init_predator
	input  logic                      s_axis_tuser,  // func
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [2*WORD_BITS-1:0]    m_axis_tdata,  // prey_out, predator_out
	output logic                      m_axis_tuser   // overflow
);

	ctrl_t                       cs;
	logic                        out_free;
	logic                        in_valid;

	logic [WORD_BITS-1:0]        prey_growth_q, predation_rate_q;
	logic [WORD_BITS-1:0]        predator_gain_q, predator_death_q;
	logic [WGT_BITS-1:0]         stage_weight_q;
	logic [WGT_BITS-1:0]         weight_rest;
	logic [WGT_BITS-1:0]         weight_wr;
	logic [STEP_BITS-1:0]        step_size_q, stage_offset_q;

	logic [WORD_BITS-1:0]        x_q, y_q;
	logic [WORD_BITS-1:0]        p_q, t0_q, t1_q, k1x_q, k1y_q, k2x_q, k2y_q, xm_q, ym_q;
	logic                        sat_q;

	logic signed [OPND_BITS-1:0] opnd_a, opnd_b;
	logic [WORD_BITS-1:0]        alu_result;
	logic                        alu_sat;

	logic                        m_valid_q;
	logic [2*WORD_BITS-1:0]      m_data_q;
	logic                        m_user_q;

	assign in_valid = s_axis_tvalid;
	assign out_free = !m_valid_q || m_axis_tready;

	lvrk2_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_func  (func_t'(s_axis_tuser)),
		.out_free (out_free),
		.cs       (cs)
	);

	// Stage weights come from the low 17 bits of the write data; above one they are held at one.
	assign weight_wr = (cfg_wdata[WGT_BITS-1:0] > WGT_ONE) ? WGT_ONE : cfg_wdata[WGT_BITS-1:0];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prey_growth_q    <= COEF_RESET;
			predation_rate_q <= COEF_RESET;
			predator_gain_q  <= COEF_RESET;
			predator_death_q <= COEF_RESET;
			stage_weight_q   <= WGT_ONE;
			step_size_q      <= STEP_RESET;
			stage_offset_q   <= OFFSET_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PREY_GROWTH:    prey_growth_q    <= cfg_wdata;
				CFG_PREDATION_RATE: predation_rate_q <= cfg_wdata;
				CFG_PREDATOR_GAIN:  predator_gain_q  <= cfg_wdata;
				CFG_PREDATOR_DEATH: predator_death_q <= cfg_wdata;
				CFG_STAGE_WEIGHT:   stage_weight_q   <= weight_wr;
				CFG_STEP_SIZE:      step_size_q      <= cfg_wdata[STEP_BITS-1:0];
				CFG_STAGE_OFFSET:   stage_offset_q   <= cfg_wdata[STEP_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Weight of the first stage.
	assign weight_rest = WGT_ONE - stage_weight_q;

	// Operand selection: words and rates sign-extended; weights, step, offset zero-extended.
	always_comb begin
		case (cs.uop.a)
			SRC_X:   opnd_a = {x_q[WORD_BITS-1], x_q};
			SRC_Y:   opnd_a = {y_q[WORD_BITS-1], y_q};
			SRC_P:   opnd_a = {p_q[WORD_BITS-1], p_q};
			SRC_T0:  opnd_a = {t0_q[WORD_BITS-1], t0_q};
			SRC_T1:  opnd_a = {t1_q[WORD_BITS-1], t1_q};
			SRC_K1X: opnd_a = {k1x_q[WORD_BITS-1], k1x_q};
			SRC_K1Y: opnd_a = {k1y_q[WORD_BITS-1], k1y_q};
			SRC_K2X: opnd_a = {k2x_q[WORD_BITS-1], k2x_q};
			SRC_K2Y: opnd_a = {k2y_q[WORD_BITS-1], k2y_q};
			SRC_XM:  opnd_a = {xm_q[WORD_BITS-1], xm_q};
			SRC_YM:  opnd_a = {ym_q[WORD_BITS-1], ym_q};
			SRC_A:   opnd_a = {prey_growth_q[WORD_BITS-1], prey_growth_q};
			SRC_B:   opnd_a = {predation_rate_q[WORD_BITS-1], predation_rate_q};
			SRC_C:   opnd_a = {predator_gain_q[WORD_BITS-1], predator_gain_q};
			SRC_D:   opnd_a = {predator_death_q[WORD_BITS-1], predator_death_q};
			SRC_OM:  opnd_a = {{(OPND_BITS-WGT_BITS){1'b0}}, weight_rest};
			SRC_W:   opnd_a = {{(OPND_BITS-WGT_BITS){1'b0}}, stage_weight_q};
			SRC_H:   opnd_a = {{(OPND_BITS-STEP_BITS){1'b0}}, step_size_q};
			SRC_OFF: opnd_a = {{(OPND_BITS-STEP_BITS){1'b0}}, stage_offset_q};
			default: opnd_a = '0;
		endcase
		case (cs.uop.b)
			SRC_X:   opnd_b = {x_q[WORD_BITS-1], x_q};
			SRC_Y:   opnd_b = {y_q[WORD_BITS-1], y_q};
			SRC_P:   opnd_b = {p_q[WORD_BITS-1], p_q};
			SRC_T0:  opnd_b = {t0_q[WORD_BITS-1], t0_q};
			SRC_T1:  opnd_b = {t1_q[WORD_BITS-1], t1_q};
			SRC_K1X: opnd_b = {k1x_q[WORD_BITS-1], k1x_q};
			SRC_K1Y: opnd_b = {k1y_q[WORD_BITS-1], k1y_q};
			SRC_K2X: opnd_b = {k2x_q[WORD_BITS-1], k2x_q};
			SRC_K2Y: opnd_b = {k2y_q[WORD_BITS-1], k2y_q};
			SRC_XM:  opnd_b = {xm_q[WORD_BITS-1], xm_q};
			SRC_YM:  opnd_b = {ym_q[WORD_BITS-1], ym_q};
			SRC_A:   opnd_b = {prey_growth_q[WORD_BITS-1], prey_growth_q};
			SRC_B:   opnd_b = {predation_rate_q[WORD_BITS-1], predation_rate_q};
			SRC_C:   opnd_b = {predator_gain_q[WORD_BITS-1], predator_gain_q};
			SRC_D:   opnd_b = {predator_death_q[WORD_BITS-1], predator_death_q};
			SRC_OM:  opnd_b = {{(OPND_BITS-WGT_BITS){1'b0}}, weight_rest};
			SRC_W:   opnd_b = {{(OPND_BITS-WGT_BITS){1'b0}}, stage_weight_q};
			SRC_H:   opnd_b = {{(OPND_BITS-STEP_BITS){1'b0}}, step_size_q};
			SRC_OFF: opnd_b = {{(OPND_BITS-STEP_BITS){1'b0}}, stage_offset_q};
			default: opnd_b = '0;
		endcase
	end

	lvrk2_alu u_alu (
		.clk    (clk),
		.op     (cs.uop.op),
		.a      (opnd_a),
		.b      (opnd_b),
		.result (alu_result),
		.sat    (alu_sat)
	);

	// Prey and predator levels: set by a load, updated at the end of a step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (cs.load_init) begin
			x_q <= s_axis_tdata[WORD_BITS-1:0];
			y_q <= s_axis_tdata[2*WORD_BITS-1:WORD_BITS];
		end else if (cs.wr_en) begin
			if (cs.uop.dst == DST_X) begin
				x_q <= alu_result;
			end
			if (cs.uop.dst == DST_Y) begin
				y_q <= alu_result;
			end
		end
	end

	// Intermediate values of the step.
	always_ff @(posedge clk) begin
		if (cs.wr_en) begin
			case (cs.uop.dst)
				DST_P:   p_q   <= alu_result;
				DST_T0:  t0_q  <= alu_result;
				DST_T1:  t1_q  <= alu_result;
				DST_K1X: k1x_q <= alu_result;
				DST_K1Y: k1y_q <= alu_result;
				DST_K2X: k2x_q <= alu_result;
				DST_K2Y: k2y_q <= alu_result;
				DST_XM:  xm_q  <= alu_result;
				DST_YM:  ym_q  <= alu_result;
				default: begin
				end
			endcase
		end
	end

	// Sticky saturation flag for the item in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cs.clr_sat) begin
			sat_q <= 1'b0;
		end else if (cs.wr_en && alu_sat) begin
			sat_q <= 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cs.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cs.out_load) begin
			m_data_q <= {y_q, x_q};
			m_user_q <= sat_q;
		end
	end

	assign s_axis_tready = cs.ready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// A new result never overwrites one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cs.out_load |-> (!m_valid_q || m_axis_tready))
		else $error("result overwritten in the output register");

endmodule

@@ tb/lotka_volterra_rk2_step_unit_checker.sv @@
// Watches the configuration port and both item channels of the step unit,
// keeps its own copy of the coefficients and the two population levels,
// predicts the levels after every accepted input item and compares each
// accepted output item with the oldest prediction still waiting.
module lotka_volterra_rk2_step_unit_checker
	import lvrk2_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [WORD_BITS-1:0]    cfg_wdata,
	input  logic                    s_axis_tvalid,
	input  logic                    s_axis_tready,
	input  logic [2*WORD_BITS-1:0]  s_axis_tdata,  // init_prey, init_predator
	input  logic                    s_axis_tuser,  // func
	input  logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	input  logic [2*WORD_BITS-1:0]  m_axis_tdata,  // prey_out, predator_out
	input  logic                    m_axis_tuser,  // overflow
	output int                      outstanding,
	output int                      errors
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint Q_ONE = longint'(1) << FRAC_BITS;
	localparam longint Q_MAX = (longint'(1) << (WORD_BITS - 1)) - 1;
	localparam longint Q_MIN = -Q_MAX - 1;

	typedef struct {
		logic [WORD_BITS-1:0] prey;
		logic [WORD_BITS-1:0] predator;
		logic                 ovf;
	} levels_t;

	// Coefficients and levels as exact signed integers.
	longint  growth_a, predation_b, gain_c, death_d, weight, step_h, offset;
	longint  prey_lvl, predator_lvl;
	bit      clipped;
	levels_t pending_levels[$];
	levels_t want, got;
	int      faults = 0;
	int      result_no;

	assign errors = faults;

	function automatic longint word_value(input logic [WORD_BITS-1:0] v);
		return longint'($signed(v));
	endfunction

	// Saturation to the word range; any clip marks the item.
	function automatic longint clamp_word(input longint v);
		if (v > Q_MAX) begin
			clipped = 1'b1;
			return Q_MAX;
		end
		if (v < Q_MIN) begin
			clipped = 1'b1;
			return Q_MIN;
		end
		return v;
	endfunction

	// Exact product, floor shift by the fraction bits, then saturate.
	function automatic longint q_mul(input longint a, input longint b);
		return clamp_word((a * b) >>> FRAC_BITS);
	endfunction

	function automatic longint q_add(input longint a, input longint b);
		return clamp_word(a + b);
	endfunction

	function automatic longint q_sub(input longint a, input longint b);
		return clamp_word(a - b);
	endfunction

	// Lotka-Volterra slopes at one point, in the unit's order of operations.
	function automatic void slopes(input longint x, input longint y,
			output longint dx, output longint dy);
		longint p;
		p  = q_mul(x, y);
		dx = q_sub(q_mul(growth_a, x), q_mul(predation_b, p));
		dy = q_sub(q_mul(gain_c, p), q_mul(death_d, y));
	endfunction

	// Levels after one item: a load stores the given levels, an advance
	// takes one weighted two-stage step from the stored ones.
	function automatic levels_t next_levels(input func_t f,
			input logic [2*WORD_BITS-1:0] data);
		longint k1x, k1y, k2x, k2y, xm, ym, bx, by, om;
		clipped = 1'b0;
		if (f == FUNC_LOAD) begin
			prey_lvl     = word_value(data[WORD_BITS-1:0]);
			predator_lvl = word_value(data[2*WORD_BITS-1:WORD_BITS]);
		end else begin
			om = Q_ONE - weight;
			slopes(prey_lvl, predator_lvl, k1x, k1y);
			xm = q_add(prey_lvl, q_mul(k1x, offset));
			ym = q_add(predator_lvl, q_mul(k1y, offset));
			slopes(xm, ym, k2x, k2y);
			bx = q_add(q_mul(om, k1x), q_mul(weight, k2x));
			by = q_add(q_mul(om, k1y), q_mul(weight, k2y));
			prey_lvl     = q_add(prey_lvl, q_mul(step_h, bx));
			predator_lvl = q_add(predator_lvl, q_mul(step_h, by));
		end
		return '{prey_lvl[WORD_BITS-1:0], predator_lvl[WORD_BITS-1:0], clipped};
	endfunction

	// Everything is sampled at the rising edge, before the block updates.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			growth_a     = word_value(COEF_RESET);
			predation_b  = word_value(COEF_RESET);
			gain_c       = word_value(COEF_RESET);
			death_d      = word_value(COEF_RESET);
			weight       = longint'(WGT_ONE);
			step_h       = longint'(STEP_RESET);
			offset       = longint'(OFFSET_RESET);
			prey_lvl     = 0;
			predator_lvl = 0;
			result_no    = 0;
			pending_levels.delete();
			outstanding <= 0;
		end else begin
			// Register writes; an index past the list changes nothing.
			if (cfg_we) begin
				case (cfg_index)
					CFG_PREY_GROWTH:    growth_a    = word_value(cfg_wdata);
					CFG_PREDATION_RATE: predation_b = word_value(cfg_wdata);
					CFG_PREDATOR_GAIN:  gain_c      = word_value(cfg_wdata);
					CFG_PREDATOR_DEATH: death_d     = word_value(cfg_wdata);
					CFG_STAGE_WEIGHT: begin
						// A weight above one in the low 17 bits counts as exactly one.
						weight = (cfg_wdata[WGT_BITS-1:0] > WGT_ONE) ?
							Q_ONE : longint'(cfg_wdata[WGT_BITS-1:0]);
					end
					CFG_STEP_SIZE:    step_h = longint'(cfg_wdata[STEP_BITS-1:0]);
					CFG_STAGE_OFFSET: offset = longint'(cfg_wdata[STEP_BITS-1:0]);
					default: ;
				endcase
			end

			// Output items against the oldest prediction.
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata[WORD_BITS-1:0],
					m_axis_tdata[2*WORD_BITS-1:WORD_BITS], m_axis_tuser};
				if (pending_levels.size() == 0) begin
					faults++;
					if (faults <= 10)
						$display("result %0d arrived with nothing expected: prey %h predator %h overflow %b",
							result_no, got.prey, got.predator, got.ovf);
				end else begin
					want = pending_levels.pop_front();
					if (got.prey !== want.prey || got.predator !== want.predator ||
							got.ovf !== want.ovf) begin
						faults++;
						if (faults <= 10)
							$display("result %0d: expected prey %h predator %h overflow %b, got prey %h predator %h overflow %b",
								result_no, want.prey, want.predator, want.ovf,
								got.prey, got.predator, got.ovf);
					end
				end
				result_no++;
			end

			// Input items produce one prediction each.
			if (s_axis_tvalid && s_axis_tready)
				pending_levels.push_back(next_levels(func_t'(s_axis_tuser), s_axis_tdata));

			outstanding <= pending_levels.size();
		end
	end

endmodule

@@ tb/lotka_volterra_rk2_step_unit_tb.sv @@
module lotka_volterra_rk2_step_unit_tb
	import lvrk2_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 3'd7;
	localparam logic [WORD_BITS-1:0]    LEVEL_TWO = 32'h0002_0000;
	localparam int PHASES     = 12;
	localparam int PHASE_ITEMS = 75;

	typedef struct {
		logic [WORD_BITS-1:0] a, b, c, d, w, h, off;
	} coeffs_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [WORD_BITS-1:0]   cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [2*WORD_BITS-1:0] s_axis_tdata;  // init_prey, init_predator
	logic                   s_axis_tuser;  // func
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [2*WORD_BITS-1:0] m_axis_tdata;  // prey_out, predator_out
	logic                   m_axis_tuser;  // overflow
	int                     outstanding;
	int                     errors;
	bit                     calm = 1'b0;

	always #6 clk = ~clk;

	lotka_volterra_rk2_step_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	lotka_volterra_rk2_step_unit_checker level_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.outstanding   (outstanding),
		.errors        (errors)
	);

	// A population level of modest size, now and then negative.
	function automatic logic [WORD_BITS-1:0] plain_level();
		logic [WORD_BITS-1:0] v;
		v = $urandom_range(32'h0000_2000, 32'h0006_0000);
		if ($urandom_range(0, 15) == 0)
			v = -v;
		return v;
	endfunction

	// Coefficients of a well-behaved system, offset worked out from h and the stage weight.
	function automatic coeffs_t plain_coeffs();
		coeffs_t cs;
		longint  span;
		cs.a = $urandom_range(6554, 131072);
		cs.b = $urandom_range(6554, 131072);
		cs.c = $urandom_range(6554, 131072);
		cs.d = $urandom_range(6554, 131072);
		cs.w = $urandom_range(0, 32'h0001_0000);
		cs.h = $urandom_range(655, 32768);
		if (cs.w == 0) begin
			cs.off = $urandom_range(0, 65536);
		end else begin
			span   = (longint'(cs.h) << FRAC_BITS) / (2 * longint'(cs.w));
			cs.off = span[WORD_BITS-1:0] & {1'b0, {(WORD_BITS-1){1'b1}}};
		end
		return cs;
	endfunction

	function automatic logic [WORD_BITS-1:0] edge_value();
		case ($urandom_range(0, 4))
			0:       return WORD_MIN;
			1:       return WORD_MAX;
			2:       return '0;
			3:       return COEF_RESET;
			default: return '1;
		endcase
	endfunction

	function automatic coeffs_t edge_coeffs();
		return '{edge_value(), edge_value(), edge_value(), edge_value(),
			edge_value(), edge_value(), edge_value()};
	endfunction

	function automatic coeffs_t wild_coeffs();
		return '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	// One input item, now and then after a random burst of idling.
	task automatic send_item(input func_t f, input logic [WORD_BITS-1:0] prey,
			input logic [WORD_BITS-1:0] predator);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {predator, prey};
		s_axis_tuser  <= f;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stop sending and wait until every predicted result has come back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [WORD_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Writes every register while the block is idle, plus one to an unused index.
	task automatic program_coeffs(input coeffs_t cs);
		drain();
		put_reg(CFG_PREY_GROWTH, cs.a);
		put_reg(CFG_PREDATION_RATE, cs.b);
		put_reg(CFG_PREDATOR_GAIN, cs.c);
		put_reg(CFG_PREDATOR_DEATH, cs.d);
		put_reg(CFG_STAGE_WEIGHT, cs.w);
		put_reg(CFG_STEP_SIZE, cs.h);
		put_reg(CFG_STAGE_OFFSET, cs.off);
		put_reg(CFG_SPARE, $urandom);
		cfg_we <= 1'b0;
	endtask

	// Receiver side: bursts of stalls between longer ready stretches.
	initial begin
		int span;
		bit hold;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (calm) begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end else begin
				hold = ($urandom_range(0, 2) == 0);
				span = hold ? $urandom_range(1, 19) : $urandom_range(1, 60);
				m_axis_tready <= !hold;
				repeat (span) @(posedge clk);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		coeffs_t cs;
		int      roll;
		int      count;
		int      run;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_wdata     <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= FUNC_LOAD;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset coefficients: a step from the zero
		// point, ordinary steps, and loads of the word extremes.
		send_item(FUNC_ADVANCE, '1, '1);
		send_item(FUNC_LOAD, LEVEL_TWO, COEF_RESET);
		send_item(FUNC_ADVANCE, '0, '0);
		send_item(FUNC_ADVANCE, $urandom, $urandom);
		send_item(FUNC_LOAD, WORD_MAX, WORD_MAX);
		send_item(FUNC_ADVANCE, '0, '0);
		send_item(FUNC_LOAD, WORD_MIN, WORD_MIN);
		send_item(FUNC_ADVANCE, '1, '0);
		send_item(FUNC_LOAD, WORD_MAX, WORD_MIN);
		send_item(FUNC_ADVANCE, '0, '1);
		send_item(FUNC_LOAD, 32'hFFFE_8000, 32'h0000_C000);
		send_item(FUNC_ADVANCE, '1, '1);
		send_item(FUNC_ADVANCE, $urandom, $urandom);

		// Extreme coefficients; the weight written far above one.
		program_coeffs('{WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, '1, '1, '1});
		send_item(FUNC_LOAD, COEF_RESET, COEF_RESET);
		send_item(FUNC_ADVANCE, '0, '0);
		send_item(FUNC_ADVANCE, '0, '0);

		// Everything zero: the levels must not move.
		program_coeffs('{'0, '0, '0, '0, '0, '0, '0});
		send_item(FUNC_LOAD, $urandom, $urandom);
		send_item(FUNC_ADVANCE, $urandom, $urandom);

		cs = '{WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN, 32'h0000_8000, WORD_MAX, '0};
		program_coeffs(cs);
		send_item(FUNC_LOAD, plain_level(), plain_level());
		send_item(FUNC_ADVANCE, '0, '0);

		// Random part: mostly a load followed by a run of steps.
		for (int phase = 0; phase < PHASES; phase++) begin
			roll = $urandom_range(0, 9);
			if (phase == 0 || roll < 6)
				cs = plain_coeffs();
			else if (roll < 8)
				cs = edge_coeffs();
			else
				cs = wild_coeffs();
			program_coeffs(cs);
			calm  = (phase == PHASES - 1);
			count = 0;
			while (count < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(func_t'($urandom_range(0, 1)), $urandom, $urandom);
					count++;
				end else begin
					if ($urandom_range(0, 7) == 0)
						send_item(FUNC_LOAD, $urandom, $urandom);
					else
						send_item(FUNC_LOAD, plain_level(), plain_level());
					run = $urandom_range(1, 12);
					repeat (run) send_item(FUNC_ADVANCE, $urandom, $urandom);
					count += run + 1;
				end
			end
		end

		drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("PASS lotka_volterra_rk2_step_unit");
		else
			$display("FAIL lotka_volterra_rk2_step_unit");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#10_000_000;
		$display("FAIL lotka_volterra_rk2_step_unit");
		$finish;
	end

endmodule

@@ files.f @@
rtl/lvrk2_pkg.sv
rtl/lvrk2_alu.sv
rtl/lvrk2_ctrl.sv
rtl/lotka_volterra_rk2_step_unit.sv
tb/lotka_volterra_rk2_step_unit_checker.sv
tb/lotka_volterra_rk2_step_unit_tb.sv
